// ----- rtl/core/nsh_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_pkg: shared types and widths for the nearest sphere hit unit
// Fixed-point widths of the ray/sphere datapath and the token that
// travels down the pipeline with every ray/sphere pair.
// ---------------------------------------------------------------------------
package nsh_pkg;

  localparam int MAX_SPHERES = 64;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W       = 7;
  localparam int SLOT_W      = 6;

  localparam int POS_W   = 32;
  localparam int DIR_W   = 18;
  localparam int DIST_W  = 32;
  localparam int L_W     = POS_W + 1;                 // centre - origin
  localparam int PROD_W  = L_W + DIR_W;               // dir * L
  localparam int DOT_W   = PROD_W + 2;                // sum of three
  localparam int SQF_W   = 2 * L_W;                   // full square
  localparam int SQ_W    = SQF_W - FRAC_BITS;         // rescaled square
  localparam int LL_W    = SQ_W + 2;
  localparam int TCA_W   = 31;                        // saturated to 2^31-1
  localparam int TCA2F_W = 2 * TCA_W;
  localparam int TCA2_W  = TCA2F_W - FRAC_BITS;
  localparam int D2_W    = LL_W + 2;
  localparam int ARG_W   = 63 - FRAC_BITS;            // clamp limit width
  localparam int ROOT_W  = 32;
  localparam int X_W     = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 4;
  localparam int T_W     = ROOT_W + 2;                // tca +/- thc, signed
  localparam int SPH_W   = 4 * POS_W;                 // one table row

  // one ray/sphere pair in flight
  typedef struct packed {
    logic             valid;   // slot carries a pair or an empty-ray marker
    logic             test;    // sphere still a candidate
    logic             last;    // final pair of its ray
    logic [IDX_W-1:0] idx;     // sphere index
  } token_t;

endpackage

// ----- rtl/core/nsh_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_if: channel interfaces of the nearest sphere hit unit
// Item, result and configuration channels, each valid/ready.
// ---------------------------------------------------------------------------
interface nsh_item_if;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [5:0]               sphere_slot;
  logic signed [31:0]       pos_x;
  logic signed [31:0]       pos_y;
  logic signed [31:0]       pos_z;
  logic signed [17:0]       dir_x;
  logic signed [17:0]       dir_y;
  logic signed [17:0]       dir_z;
  logic [31:0]              radius_squared;

  modport source (output valid, action, sphere_slot, pos_x, pos_y, pos_z,
                  dir_x, dir_y, dir_z, radius_squared, input ready);
  modport sink   (input valid, action, sphere_slot, pos_x, pos_y, pos_z,
                  dir_x, dir_y, dir_z, radius_squared, output ready);
endinterface

interface nsh_result_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [5:0]         nearest_index;
  logic signed [31:0] hit_distance;

  modport source (output valid, hit, nearest_index, hit_distance, input ready);
  modport sink   (input valid, hit, nearest_index, hit_distance, output ready);
endinterface

interface nsh_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] sphere_count;

  modport source (output valid, sphere_count, input ready);
  modport sink   (input valid, sphere_count, output ready);
endinterface

// ----- rtl/core/nearest_sphere_hit_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_sphere_hit_unit: nearest ray/sphere intersection, Q16.16
// Sphere table loaded by load transactions; each ray transaction is tested
// against the first sphere_count spheres and gives one result.
//
//   channel  dir  carries
//   cfg      in   sphere_count write (always ready)
//   item     in   load (action 0) or ray (action 1)
//   result   out  hit, nearest_index, hit_distance (one per ray)
//
// A ray issues max(min(sphere_count, 64), 1) pairs, one sphere per cycle
// while the result is not stalled, set by the single table read port;
// results pass stage A, the geometry, sqrt and pick stages after issue.
// Reset (rst, synchronous) clears the pipeline valid bits and the count;
// the sphere table is not cleared. A stalled result freezes the whole pipe.
// ---------------------------------------------------------------------------
module nearest_sphere_hit_unit (
  input  logic          clk,
  input  logic          rst,
  nsh_cfg_if.sink       cfg,
  nsh_item_if.sink      item,
  nsh_result_if.source  result
);

  logic [nsh_pkg::CNT_W-1:0]        sphere_count;
  logic                             adv;
  nsh_pkg::token_t                  tok_a, tok_g, tok_s;
  logic signed [nsh_pkg::POS_W-1:0] org_x, org_y, org_z;
  logic signed [nsh_pkg::DIR_W-1:0] ray_dx, ray_dy, ray_dz;
  logic [nsh_pkg::SPH_W-1:0]        sph_row;
  logic [nsh_pkg::ARG_W-1:0]        arg_g;
  logic [nsh_pkg::TCA_W-1:0]        tca_g, tca_s;
  logic [nsh_pkg::ROOT_W-1:0]       thc;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
    end else if (cfg.valid) begin
      sphere_count <= cfg.sphere_count;
    end
  end

  nsh_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .sphere_count (sphere_count),
    .item         (item),
    .tok_a        (tok_a),
    .org_x        (org_x),
    .org_y        (org_y),
    .org_z        (org_z),
    .ray_dx       (ray_dx),
    .ray_dy       (ray_dy),
    .ray_dz       (ray_dz),
    .sph_row      (sph_row)
  );

  nsh_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tok_a   (tok_a),
    .org_x   (org_x),
    .org_y   (org_y),
    .org_z   (org_z),
    .ray_dx  (ray_dx),
    .ray_dy  (ray_dy),
    .ray_dz  (ray_dz),
    .sph_row (sph_row),
    .tok_g   (tok_g),
    .arg_g   (arg_g),
    .tca_g   (tca_g)
  );

  nsh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .tok_in   (tok_g),
    .arg_in   (arg_g),
    .tca_in   (tca_g),
    .tok_out  (tok_s),
    .root_out (thc),
    .tca_out  (tca_s)
  );

  nsh_pick u_pick (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .tok_s  (tok_s),
    .thc    (thc),
    .tca    (tca_s),
    .result (result)
  );

endmodule

// ----- rtl/core/nsh_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module nsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/nsh_seq.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_seq: item intake, sphere table and pair issue
// Loads write the sphere table; a ray issues one pair per sphere (or one
// empty-ray marker) into the pipeline, with the table row read alongside.
// ---------------------------------------------------------------------------
module nsh_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [nsh_pkg::CNT_W-1:0]     sphere_count,
  nsh_item_if.sink                      item,
  output nsh_pkg::token_t               tok_a,
  output logic signed [nsh_pkg::POS_W-1:0] org_x,
  output logic signed [nsh_pkg::POS_W-1:0] org_y,
  output logic signed [nsh_pkg::POS_W-1:0] org_z,
  output logic signed [nsh_pkg::DIR_W-1:0] ray_dx,
  output logic signed [nsh_pkg::DIR_W-1:0] ray_dy,
  output logic signed [nsh_pkg::DIR_W-1:0] ray_dz,
  output logic [nsh_pkg::SPH_W-1:0]     sph_row
);

  logic                          busy;
  logic [nsh_pkg::IDX_W-1:0]     idx;
  logic [nsh_pkg::IDX_W-1:0]     lim;
  logic                          empty;
  logic signed [nsh_pkg::POS_W-1:0] ray_ox, ray_oy, ray_oz;
  logic signed [nsh_pkg::DIR_W-1:0] ray_vx, ray_vy, ray_vz;
  logic                          last_issue;
  logic                          accept;
  logic                          load_we;
  logic                          ray_acc;
  logic [nsh_pkg::CNT_W-1:0]     n_eff;
  nsh_pkg::token_t               tok_next;

  // clamp the count to the table size
  assign n_eff = (32'(sphere_count) > nsh_pkg::MAX_SPHERES) ?
                 nsh_pkg::CNT_W'(nsh_pkg::MAX_SPHERES) : sphere_count;

  assign last_issue = busy && (idx == lim);
  assign item.ready = adv && (!busy || last_issue);
  assign accept     = item.valid && item.ready;
  assign ray_acc    = accept && item.action;
  assign load_we    = accept && !item.action &&
                      (32'(item.sphere_slot) < nsh_pkg::MAX_SPHERES);

  // sphere table: x, y, z, r2 in one row
  nsh_ram #(.WIDTH(nsh_pkg::SPH_W), .DEPTH(nsh_pkg::MAX_SPHERES)) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (nsh_pkg::IDX_W'(item.sphere_slot)),
    .wdata ({item.pos_x, item.pos_y, item.pos_z, item.radius_squared}),
    .re    (adv),
    .raddr (idx),
    .rdata (sph_row)
  );

  // issue control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (adv) begin
      if (ray_acc) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (last_issue) begin
        busy <= 1'b0;
      end else if (busy) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // ray held while its pairs issue
  always_ff @(posedge clk) begin
    if (ray_acc) begin
      ray_ox <= item.pos_x;
      ray_oy <= item.pos_y;
      ray_oz <= item.pos_z;
      ray_vx <= item.dir_x;
      ray_vy <= item.dir_y;
      ray_vz <= item.dir_z;
      empty  <= (n_eff == '0);
      lim    <= (n_eff == '0) ? '0 : nsh_pkg::IDX_W'(n_eff - 1'b1);
    end
  end

  always_comb begin
    tok_next.valid = busy;
    tok_next.test  = busy && !empty;
    tok_next.last  = last_issue;
    tok_next.idx   = idx;
  end

  // stage A: aligned with the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a <= '0;
    end else if (adv) begin
      tok_a <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      org_x  <= ray_ox;
      org_y  <= ray_oy;
      org_z  <= ray_oz;
      ray_dx <= ray_vx;
      ray_dy <= ray_vy;
      ray_dz <= ray_vz;
    end
  end

endmodule

// ----- rtl/core/nsh_geom.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_geom: geometric ray/sphere test
// Six stages: offset, products, sums, tca, tca squared, sqrt argument.
// ---------------------------------------------------------------------------
module nsh_geom (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  nsh_pkg::token_t                  tok_a,
  input  logic signed [nsh_pkg::POS_W-1:0] org_x,
  input  logic signed [nsh_pkg::POS_W-1:0] org_y,
  input  logic signed [nsh_pkg::POS_W-1:0] org_z,
  input  logic signed [nsh_pkg::DIR_W-1:0] ray_dx,
  input  logic signed [nsh_pkg::DIR_W-1:0] ray_dy,
  input  logic signed [nsh_pkg::DIR_W-1:0] ray_dz,
  input  logic [nsh_pkg::SPH_W-1:0]        sph_row,
  output nsh_pkg::token_t                  tok_g,
  output logic [nsh_pkg::ARG_W-1:0]        arg_g,
  output logic [nsh_pkg::TCA_W-1:0]        tca_g
);

  localparam int P = nsh_pkg::POS_W;

  nsh_pkg::token_t tok_b, tok_c, tok_d, tok_e, tok_f, tok_fm;

  logic signed [nsh_pkg::POS_W-1:0] cx, cy, cz;
  logic [nsh_pkg::POS_W-1:0]        r2_a;

  // B
  logic signed [nsh_pkg::L_W-1:0]   lx_b, ly_b, lz_b;
  logic [nsh_pkg::L_W-1:0]          ax_b, ay_b, az_b;
  logic signed [nsh_pkg::DIR_W-1:0] dx_b, dy_b, dz_b;
  logic [nsh_pkg::POS_W-1:0]        r2_b;
  // C
  logic signed [nsh_pkg::PROD_W-1:0] px_c, py_c, pz_c;
  logic [nsh_pkg::SQ_W-1:0]          sx_c, sy_c, sz_c;
  logic [nsh_pkg::POS_W-1:0]         r2_c;
  logic [nsh_pkg::SQF_W-1:0]         sqx, sqy, sqz;
  // D
  logic signed [nsh_pkg::DOT_W-1:0] dot_d;
  logic [nsh_pkg::LL_W-1:0]         ll_d;
  logic [nsh_pkg::POS_W-1:0]        r2_d;
  // E
  logic [nsh_pkg::TCA_W-1:0]        tca_e;
  logic                             neg_e;
  logic [nsh_pkg::LL_W-1:0]         ll_e;
  logic [nsh_pkg::POS_W-1:0]        r2_e;
  logic [nsh_pkg::DOT_W-nsh_pkg::FRAC_BITS-1:0] dsh;
  // F
  logic [nsh_pkg::TCA2_W-1:0]       tca2_f;
  logic [nsh_pkg::TCA_W-1:0]        tca_f;
  logic                             neg_f;
  logic [nsh_pkg::LL_W-1:0]         ll_f;
  logic [nsh_pkg::POS_W-1:0]        r2_f;
  logic [nsh_pkg::TCA2F_W-1:0]      tsq;
  // G
  logic signed [nsh_pkg::D2_W-1:0]  d2, argw;
  logic                             miss;
  logic [nsh_pkg::ARG_W-1:0]        arg_sat;

  assign cx   = sph_row[4*P-1:3*P];
  assign cy   = sph_row[3*P-1:2*P];
  assign cz   = sph_row[2*P-1:P];
  assign r2_a = sph_row[P-1:0];

  // candidate flag dropped on a miss
  always_comb begin
    tok_fm      = tok_f;
    tok_fm.test = tok_f.test && !miss;
  end

  // token valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_b <= '0;
      tok_c <= '0;
      tok_d <= '0;
      tok_e <= '0;
      tok_f <= '0;
      tok_g <= '0;
    end else if (adv) begin
      tok_b <= tok_a;
      tok_c <= tok_b;
      tok_d <= tok_c;
      tok_e <= tok_d;
      tok_f <= tok_e;
      tok_g <= tok_fm;
    end
  end

  // B: L = centre - origin and its magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      lx_b <= nsh_pkg::L_W'(cx) - nsh_pkg::L_W'(org_x);
      ly_b <= nsh_pkg::L_W'(cy) - nsh_pkg::L_W'(org_y);
      lz_b <= nsh_pkg::L_W'(cz) - nsh_pkg::L_W'(org_z);
      dx_b <= ray_dx;
      dy_b <= ray_dy;
      dz_b <= ray_dz;
      r2_b <= r2_a;
    end
  end

  assign ax_b = lx_b[nsh_pkg::L_W-1] ? -lx_b : lx_b;
  assign ay_b = ly_b[nsh_pkg::L_W-1] ? -ly_b : ly_b;
  assign az_b = lz_b[nsh_pkg::L_W-1] ? -lz_b : lz_b;

  // C: direction products and rescaled squares
  assign sqx = nsh_pkg::SQF_W'(ax_b) * nsh_pkg::SQF_W'(ax_b);
  assign sqy = nsh_pkg::SQF_W'(ay_b) * nsh_pkg::SQF_W'(ay_b);
  assign sqz = nsh_pkg::SQF_W'(az_b) * nsh_pkg::SQF_W'(az_b);

  always_ff @(posedge clk) begin
    if (adv) begin
      px_c <= nsh_pkg::PROD_W'(dx_b) * nsh_pkg::PROD_W'(lx_b);
      py_c <= nsh_pkg::PROD_W'(dy_b) * nsh_pkg::PROD_W'(ly_b);
      pz_c <= nsh_pkg::PROD_W'(dz_b) * nsh_pkg::PROD_W'(lz_b);
      sx_c <= sqx[nsh_pkg::SQF_W-1:nsh_pkg::FRAC_BITS];
      sy_c <= sqy[nsh_pkg::SQF_W-1:nsh_pkg::FRAC_BITS];
      sz_c <= sqz[nsh_pkg::SQF_W-1:nsh_pkg::FRAC_BITS];
      r2_c <= r2_b;
    end
  end

  // D: dot(dir, L) and dot(L, L)
  always_ff @(posedge clk) begin
    if (adv) begin
      dot_d <= nsh_pkg::DOT_W'(px_c) + nsh_pkg::DOT_W'(py_c) + nsh_pkg::DOT_W'(pz_c);
      ll_d  <= nsh_pkg::LL_W'(sx_c) + nsh_pkg::LL_W'(sy_c) + nsh_pkg::LL_W'(sz_c);
      r2_d  <= r2_c;
    end
  end

  // E: tca, floor shift and saturation
  assign dsh = dot_d[nsh_pkg::DOT_W-1:nsh_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_e <= dot_d[nsh_pkg::DOT_W-1];
      tca_e <= (|dsh[nsh_pkg::DOT_W-nsh_pkg::FRAC_BITS-1:nsh_pkg::TCA_W]) ?
               '1 : dsh[nsh_pkg::TCA_W-1:0];
      ll_e  <= ll_d;
      r2_e  <= r2_d;
    end
  end

  // F: tca squared
  assign tsq = nsh_pkg::TCA2F_W'(tca_e) * nsh_pkg::TCA2F_W'(tca_e);

  always_ff @(posedge clk) begin
    if (adv) begin
      tca2_f <= tsq[nsh_pkg::TCA2F_W-1:nsh_pkg::FRAC_BITS];
      tca_f  <= tca_e;
      neg_f  <= neg_e;
      ll_f   <= ll_e;
      r2_f   <= r2_e;
    end
  end

  // G: d2 against r2, sqrt argument clamped
  assign d2   = nsh_pkg::D2_W'(ll_f) - nsh_pkg::D2_W'(tca2_f);
  assign argw = nsh_pkg::D2_W'(r2_f) - d2;
  assign miss = neg_f || argw[nsh_pkg::D2_W-1];
  assign arg_sat = (|argw[nsh_pkg::D2_W-2:nsh_pkg::ARG_W]) ? '1 :
                   argw[nsh_pkg::ARG_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      arg_g <= miss ? '0 : arg_sat;
      tca_g <= tca_f;
    end
  end

endmodule

// ----- rtl/core/nsh_sqrt.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_sqrt: pipelined integer square root
// floor(sqrt(arg << FRAC_BITS)), one root bit per stage.
// ---------------------------------------------------------------------------
module nsh_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  nsh_pkg::token_t             tok_in,
  input  logic [nsh_pkg::ARG_W-1:0]   arg_in,
  input  logic [nsh_pkg::TCA_W-1:0]   tca_in,
  output nsh_pkg::token_t             tok_out,
  output logic [nsh_pkg::ROOT_W-1:0]  root_out,
  output logic [nsh_pkg::TCA_W-1:0]   tca_out
);

  localparam int N = nsh_pkg::ROOT_W;

  nsh_pkg::token_t                tok_r [N];
  logic [nsh_pkg::REM_W-1:0]      rem_r [N];
  logic [nsh_pkg::ROOT_W-1:0]     q_r   [N];
  logic [nsh_pkg::X_W-1:0]        x_r   [N];
  logic [nsh_pkg::TCA_W-1:0]      tca_r [N];

  logic [nsh_pkg::X_W-1:0]        x_init;

  assign x_init = nsh_pkg::X_W'(arg_in) << nsh_pkg::FRAC_BITS;

  for (genvar s = 0; s < N; s++) begin : g_stage
    nsh_pkg::token_t            tok_i;
    logic [nsh_pkg::REM_W-1:0]  rem_i, rem_sh, trial;
    logic [nsh_pkg::ROOT_W-1:0] q_i;
    logic [nsh_pkg::X_W-1:0]    x_i;
    logic [nsh_pkg::TCA_W-1:0]  tca_i;
    logic                       ge;

    if (s == 0) begin : g_first
      assign tok_i = tok_in;
      assign rem_i = '0;
      assign q_i   = '0;
      assign x_i   = x_init;
      assign tca_i = tca_in;
    end else begin : g_next
      assign tok_i = tok_r[s-1];
      assign rem_i = rem_r[s-1];
      assign q_i   = q_r[s-1];
      assign x_i   = x_r[s-1];
      assign tca_i = tca_r[s-1];
    end

    // bring down two bits, try 4q+1
    assign rem_sh = {rem_i[nsh_pkg::REM_W-3:0], x_i[nsh_pkg::X_W-1:nsh_pkg::X_W-2]};
    assign trial  = nsh_pkg::REM_W'({q_i, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        tok_r[s] <= '0;
      end else if (adv) begin
        tok_r[s] <= tok_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= ge ? (rem_sh - trial) : rem_sh;
        q_r[s]   <= {q_i[nsh_pkg::ROOT_W-2:0], ge};
        x_r[s]   <= x_i << 2;
        tca_r[s] <= tca_i;
      end
    end
  end

  assign tok_out  = tok_r[N-1];
  assign root_out = q_r[N-1];
  assign tca_out  = tca_r[N-1];

endmodule

// ----- rtl/core/nsh_pick.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsh_pick: hit distance and nearest-hit selection
// Forms t from tca and thc, keeps the running minimum per ray and holds
// the result in the output register.
// ---------------------------------------------------------------------------
module nsh_pick (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        adv,
  input  nsh_pkg::token_t             tok_s,
  input  logic [nsh_pkg::ROOT_W-1:0]  thc,
  input  logic [nsh_pkg::TCA_W-1:0]   tca,
  nsh_result_if.source                result
);

  nsh_pkg::token_t               tok_t;
  logic [nsh_pkg::TCA_W-1:0]     t_t;
  logic signed [nsh_pkg::T_W-1:0] t0, t1, tsel;

  logic                          found;
  logic [nsh_pkg::TCA_W-1:0]     best_t;
  logic [nsh_pkg::IDX_W-1:0]     best_idx;

  logic                          take;
  logic                          fin_hit;
  logic [nsh_pkg::TCA_W-1:0]     fin_t;
  logic [nsh_pkg::IDX_W-1:0]     fin_idx;

  assign adv = !result.valid || result.ready;

  // T: pick near or far root, saturate
  assign t0   = nsh_pkg::T_W'(tca) - nsh_pkg::T_W'(thc);
  assign t1   = nsh_pkg::T_W'(tca) + nsh_pkg::T_W'(thc);
  assign tsel = t0[nsh_pkg::T_W-1] ? t1 : t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_t <= '0;
    end else if (adv) begin
      tok_t <= tok_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_t <= (|tsel[nsh_pkg::T_W-1:nsh_pkg::TCA_W]) ? '1 : tsel[nsh_pkg::TCA_W-1:0];
    end
  end

  // running minimum; ties keep the earlier index
  assign take    = tok_t.test && (!found || (t_t < best_t));
  assign fin_hit = found || tok_t.test;
  assign fin_t   = take ? t_t : best_t;
  assign fin_idx = take ? tok_t.idx : best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (adv && tok_t.valid) begin
      found <= tok_t.last ? 1'b0 : fin_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_t.valid && take) begin
      best_t   <= t_t;
      best_idx <= tok_t.idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= tok_t.valid && tok_t.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_t.valid && tok_t.last) begin
      result.hit           <= fin_hit;
      result.nearest_index <= fin_hit ? 6'(fin_idx) : '0;
      result.hit_distance  <= fin_hit ? nsh_pkg::DIST_W'(fin_t) : '0;
    end
  end

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.hit |-> result.nearest_index == '0 &&
                                    result.hit_distance == '0)
    else $error("miss result carries index or distance");

  a_dist_pos: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.hit |-> !result.hit_distance[nsh_pkg::DIST_W-1])
    else $error("hit distance negative");

  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    adv && tok_t.valid && tok_t.last |=> !found)
    else $error("accumulator not cleared after ray end");

endmodule
